[rtl/fps_pkg.sv]
// ----------------------------------------------------------------------------
// fps_pkg
// shared codes, widths and result layout for the flight phase sequencer
// ----------------------------------------------------------------------------
package fps_pkg;

    localparam int TIME_W  = 32;
    localparam int OP_W    = 4;
    localparam int PHASE_W = 3;
    localparam int IN_W    = 40;
    localparam int OUT_W   = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W   = 32;

    localparam logic [PHASE_W-1:0] PH_IDLE   = 3'd0;
    localparam logic [PHASE_W-1:0] PH_ARMED  = 3'd1;
    localparam logic [PHASE_W-1:0] PH_BOOST  = 3'd2;
    localparam logic [PHASE_W-1:0] PH_COAST  = 3'd3;
    localparam logic [PHASE_W-1:0] PH_DROGUE = 3'd4;
    localparam logic [PHASE_W-1:0] PH_MAIN   = 3'd5;
    localparam logic [PHASE_W-1:0] PH_LANDED = 3'd6;
    localparam logic [PHASE_W-1:0] PH_ABORT  = 3'd7;

    localparam logic [OP_W-1:0] OP_TICK    = 4'd0;
    localparam logic [OP_W-1:0] OP_ARM     = 4'd1;
    localparam logic [OP_W-1:0] OP_DISARM  = 4'd2;
    localparam logic [OP_W-1:0] OP_LAUNCH  = 4'd3;
    localparam logic [OP_W-1:0] OP_BURNOUT = 4'd4;
    localparam logic [OP_W-1:0] OP_APOGEE  = 4'd5;
    localparam logic [OP_W-1:0] OP_MAIN    = 4'd6;
    localparam logic [OP_W-1:0] OP_LANDING = 4'd7;
    localparam logic [OP_W-1:0] OP_ABORT   = 4'd8;
    localparam logic [OP_W-1:0] OP_RESET   = 4'd9;

    localparam logic [CFG_IDX_W-1:0] REG_ARMED_TIMEOUT      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COAST_TIMEOUT      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ABORT_TIMEOUT      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PYRO_PRESENT       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ABORT_DROGUE_BOOST = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ABORT_DROGUE_COAST = 3'd5;

    typedef struct packed {
        logic               reset_subsystems;
        logic               beacon_start;
        logic               fire_main;
        logic               fire_drogue;
        logic               phase_changed;
        logic [PHASE_W-1:0] phase;
    } result_t;

endpackage

[rtl/flight_phase_sequencer_core.sv]
// ----------------------------------------------------------------------------
// flight_phase_sequencer_core
// flight phase state machine with timeouts, pyro pulses and beacon one-shot
// ----------------------------------------------------------------------------
// timing: a request is first held in the input register, then its result
// is held in the result register
// throughput: one request per cycle while the output is not stalled
// reset: asynchronous, clears the phase to idle, all times, flags and config
// ----------------------------------------------------------------------------
module flight_phase_sequencer_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [fps_pkg::IN_W-1:0]      s_tdata,   // operation, now_time
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [fps_pkg::OUT_W-1:0]     m_tdata,   // phase, phase_changed,
                                                     // fire_drogue, fire_main,
                                                     // beacon_start,
                                                     // reset_subsystems
    input  logic                          cfg_write_en,
    input  logic [fps_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fps_pkg::CFG_W-1:0]     cfg_data
);
    import fps_pkg::*;

    logic               in_valid_reg;
    logic [OP_W-1:0]    op_reg;
    logic [TIME_W-1:0]  time_reg;
    logic               out_valid_reg;
    result_t            result_reg;
    result_t            result_next;

    logic [PHASE_W-1:0] phase_reg;
    logic [PHASE_W-1:0] phase_next;
    logic [TIME_W-1:0]  entry_reg;
    logic [TIME_W-1:0]  entry_next;
    logic [TIME_W-1:0]  last_reg;
    logic [TIME_W-1:0]  last_next;
    logic               launched_reg;
    logic               launched_next;
    logic               beacon_done_reg;
    logic               beacon_done_next;

    logic [TIME_W-1:0]  armed_timeout_reg;
    logic [TIME_W-1:0]  coast_timeout_reg;
    logic [TIME_W-1:0]  abort_timeout_reg;
    logic               pyro_present_reg;
    logic               abort_drogue_boost_reg;
    logic               abort_drogue_coast_reg;

    logic               advance;
    logic               process;
    logic [TIME_W-1:0]  elapsed;
    logic               is_tick;
    logic               go;
    logic [PHASE_W-1:0] target;
    logic               drogue;
    logic               main_fire;
    logic               beacon;

    assign advance  = !out_valid_reg || m_tready;
    assign process  = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = result_reg;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_timeout_reg      <= '0;
            coast_timeout_reg      <= '0;
            abort_timeout_reg      <= '0;
            pyro_present_reg       <= 1'b0;
            abort_drogue_boost_reg <= 1'b0;
            abort_drogue_coast_reg <= 1'b0;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                REG_ARMED_TIMEOUT:      armed_timeout_reg      <= cfg_data;
                REG_COAST_TIMEOUT:      coast_timeout_reg      <= cfg_data;
                REG_ABORT_TIMEOUT:      abort_timeout_reg      <= cfg_data;
                REG_PYRO_PRESENT:       pyro_present_reg       <= cfg_data[0];
                REG_ABORT_DROGUE_BOOST: abort_drogue_boost_reg <= cfg_data[0];
                REG_ABORT_DROGUE_COAST: abort_drogue_coast_reg <= cfg_data[0];
                default:                ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            op_reg   <= s_tdata[OP_W-1:0];
            time_reg <= s_tdata[OP_W+TIME_W-1:OP_W];
        end
    end

    // phase update
    always_comb
    begin
        is_tick   = (op_reg == OP_TICK);
        last_next = is_tick ? time_reg : last_reg;
        elapsed   = last_next - entry_reg;
        go        = 1'b0;
        target    = phase_reg;
        drogue    = 1'b0;
        main_fire = 1'b0;
        beacon    = 1'b0;
        beacon_done_next = beacon_done_reg;
        launched_next    = launched_reg;

        case (phase_reg)
            PH_IDLE:
            begin
                if (op_reg == OP_ARM)
                begin
                    go = 1'b1;
                    target = PH_ARMED;
                end
            end
            PH_ARMED:
            begin
                if (op_reg == OP_LAUNCH)
                begin
                    go = 1'b1;
                    target = PH_BOOST;
                end
                else if (op_reg == OP_DISARM)
                begin
                    go = 1'b1;
                    target = PH_IDLE;
                end
                else if (op_reg == OP_ABORT)
                begin
                    go = 1'b1;
                    target = PH_ABORT;
                end
                else if (is_tick && (elapsed >= armed_timeout_reg))
                begin
                    go = 1'b1;
                    target = PH_IDLE;
                end
            end
            PH_BOOST:
            begin
                if (op_reg == OP_BURNOUT)
                begin
                    go = 1'b1;
                    target = PH_COAST;
                end
                else if (op_reg == OP_ABORT)
                begin
                    go = 1'b1;
                    target = PH_ABORT;
                end
            end
            PH_COAST:
            begin
                if (op_reg == OP_ABORT)
                begin
                    go = 1'b1;
                    target = PH_ABORT;
                end
                else if ((op_reg == OP_APOGEE) ||
                         (is_tick && (elapsed >= coast_timeout_reg)))
                begin
                    go = 1'b1;
                    target = PH_DROGUE;
                    drogue = pyro_present_reg;
                end
            end
            PH_DROGUE:
            begin
                if (op_reg == OP_MAIN)
                begin
                    go = 1'b1;
                    target = PH_MAIN;
                    main_fire = pyro_present_reg;
                end
                else if (op_reg == OP_LANDING)
                begin
                    go = 1'b1;
                    target = PH_LANDED;
                end
            end
            PH_MAIN:
            begin
                if (op_reg == OP_LANDING)
                begin
                    go = 1'b1;
                    target = PH_LANDED;
                end
            end
            PH_LANDED:
            begin
                if (op_reg == OP_RESET)
                begin
                    go = 1'b1;
                    target = PH_IDLE;
                end
            end
            PH_ABORT:
            begin
                if (op_reg == OP_RESET)
                begin
                    go = 1'b1;
                    target = PH_IDLE;
                end
                else if (is_tick && (elapsed >= abort_timeout_reg))
                begin
                    if (!launched_reg)
                    begin
                        go = 1'b1;
                        target = PH_IDLE;
                    end
                    else if (!beacon_done_reg)
                    begin
                        beacon_done_next = 1'b1;
                        beacon = 1'b1;
                    end
                end
            end
            default:
            begin
                go = 1'b0;
            end
        endcase

        phase_next = phase_reg;
        entry_next = entry_reg;
        result_next.reset_subsystems = 1'b0;
        if (go)
        begin
            phase_next = target;
            entry_next = last_next;
            if (target == PH_IDLE)
            begin
                launched_next    = 1'b0;
                beacon_done_next = 1'b0;
                result_next.reset_subsystems = 1'b1;
            end
            else if (target == PH_BOOST)
            begin
                launched_next = 1'b1;
            end
            else if (target == PH_ABORT)
            begin
                // abort drogue ignores pyro_present
                if ((phase_reg == PH_BOOST && abort_drogue_boost_reg) ||
                    (phase_reg == PH_COAST && abort_drogue_coast_reg))
                begin
                    drogue = 1'b1;
                end
            end
        end

        result_next.phase         = phase_next;
        result_next.phase_changed = go;
        result_next.fire_drogue   = drogue;
        result_next.fire_main     = main_fire;
        result_next.beacon_start  = beacon;
    end

    // state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            entry_reg       <= '0;
            last_reg        <= '0;
            launched_reg    <= 1'b0;
            beacon_done_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (process)
            begin
                phase_reg       <= phase_next;
                entry_reg       <= entry_next;
                last_reg        <= last_next;
                launched_reg    <= launched_next;
                beacon_done_reg <= beacon_done_next;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (process)
        begin
            result_reg <= result_next;
        end
    end

    // checks
    a_rst_means_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_reg.reset_subsystems) |->
            (result_reg.phase == PH_IDLE && result_reg.phase_changed))
        else $error("reset_subsystems without entry into idle");

    a_beacon_in_abort: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_reg.beacon_start) |->
            (result_reg.phase == PH_ABORT && !result_reg.phase_changed))
        else $error("beacon_start outside a held abort phase");

    a_main_on_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_reg.fire_main) |->
            (result_reg.phase == PH_MAIN && result_reg.phase_changed))
        else $error("fire_main without entry into main descent");

    a_launched_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_BOOST || phase_reg == PH_COAST) |-> launched_reg)
        else $error("boost or coast without launch marker");

    a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !process |=> $stable(phase_reg) && $stable(entry_reg) && $stable(last_reg))
        else $error("state moved with no request processed");

endmodule

[tb/flight_phase_sequencer_core_tb.sv]
// ----------------------------------------------------------------------------
// flight_phase_sequencer_core_tb
// self-checking bench for the flight phase sequencer: a short directed
// table, then random flight sequences under several register settings and
// idle/stall mixes, each result compared with the table's expected value or
// with a phase tracker kept in the tb
module flight_phase_sequencer_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import fps_pkg::*;

    typedef struct {
        logic [OP_W-1:0]   op;
        logic [TIME_W-1:0] stamp;
        bit                fixed;
        result_t           want;
    } row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [IN_W-1:0]      s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [OUT_W-1:0]     m_tdata;
    logic                 cfg_write_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;

    // tracked flight state and register copies
    logic [PHASE_W-1:0] trk_phase = PH_IDLE;
    logic [TIME_W-1:0]  trk_entry = '0;
    logic [TIME_W-1:0]  trk_last = '0;
    logic               trk_launched = 1'b0;
    logic               trk_beacon_done = 1'b0;
    logic [TIME_W-1:0]  armed_to = '0;
    logic [TIME_W-1:0]  coast_to = '0;
    logic [TIME_W-1:0]  abort_to = '0;
    logic               pyro_on = 1'b0;
    logic               drogue_on_boost_abort = 1'b0;
    logic               drogue_on_coast_abort = 1'b0;

    result_t           pending_results[$];
    row_t              drill[$];
    int                errors = 0;
    int                idle_pct = 0;
    int                stall_pct = 0;
    bit                hold_go = 1'b0;
    bit                hold_used = 1'b0;
    int                hold_left = 0;
    logic [TIME_W-1:0] clock_ms = '0;

    flight_phase_sequencer_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #4 clk = ~clk;

    function automatic result_t mk(logic [PHASE_W-1:0] ph, logic chg, logic drg, logic mn,
                                   logic bcn, logic rs);
        result_t r;
        r.phase = ph;
        r.phase_changed = chg;
        r.fire_drogue = drg;
        r.fire_main = mn;
        r.beacon_start = bcn;
        r.reset_subsystems = rs;
        return r;
    endfunction

    function automatic bit timed_out(logic [TIME_W-1:0] limit);
        logic [TIME_W-1:0] elapsed;
        elapsed = trk_last - trk_entry;
        return elapsed >= limit;
    endfunction

    function automatic result_t advance_phase(logic [OP_W-1:0] op, logic [TIME_W-1:0] stamp);
        result_t            r;
        logic [PHASE_W-1:0] nxt;
        logic [PHASE_W-1:0] prev;
        bit                 go;
        r = '0;
        go = 1'b0;
        prev = trk_phase;
        nxt = trk_phase;
        if (op == OP_TICK)
            trk_last = stamp;
        case (trk_phase)
            PH_IDLE:
                if (op == OP_ARM)
                begin
                    go = 1'b1;
                    nxt = PH_ARMED;
                end
            PH_ARMED:
                if (op == OP_LAUNCH)
                begin
                    go = 1'b1;
                    nxt = PH_BOOST;
                end
                else if (op == OP_DISARM || (op == OP_TICK && timed_out(armed_to)))
                begin
                    go = 1'b1;
                    nxt = PH_IDLE;
                end
                else if (op == OP_ABORT)
                begin
                    go = 1'b1;
                    nxt = PH_ABORT;
                end
            PH_BOOST:
                if (op == OP_BURNOUT)
                begin
                    go = 1'b1;
                    nxt = PH_COAST;
                end
                else if (op == OP_ABORT)
                begin
                    go = 1'b1;
                    nxt = PH_ABORT;
                end
            PH_COAST:
                if (op == OP_ABORT)
                begin
                    go = 1'b1;
                    nxt = PH_ABORT;
                end
                else if (op == OP_APOGEE || (op == OP_TICK && timed_out(coast_to)))
                begin
                    r.fire_drogue = pyro_on;
                    go = 1'b1;
                    nxt = PH_DROGUE;
                end
            PH_DROGUE:
                if (op == OP_MAIN)
                begin
                    r.fire_main = pyro_on;
                    go = 1'b1;
                    nxt = PH_MAIN;
                end
                else if (op == OP_LANDING)
                begin
                    go = 1'b1;
                    nxt = PH_LANDED;
                end
            PH_MAIN:
                if (op == OP_LANDING)
                begin
                    go = 1'b1;
                    nxt = PH_LANDED;
                end
            PH_LANDED:
                if (op == OP_RESET)
                begin
                    go = 1'b1;
                    nxt = PH_IDLE;
                end
            default:
                if (op == OP_RESET)
                begin
                    go = 1'b1;
                    nxt = PH_IDLE;
                end
                else if (op == OP_TICK && timed_out(abort_to))
                begin
                    if (!trk_launched)
                    begin
                        go = 1'b1;
                        nxt = PH_IDLE;
                    end
                    else if (!trk_beacon_done)
                    begin
                        trk_beacon_done = 1'b1;
                        r.beacon_start = 1'b1;
                    end
                end
        endcase
        if (go)
        begin
            trk_phase = nxt;
            trk_entry = trk_last;
            r.phase_changed = 1'b1;
            if (nxt == PH_IDLE)
            begin
                trk_launched = 1'b0;
                trk_beacon_done = 1'b0;
                r.reset_subsystems = 1'b1;
            end
            else if (nxt == PH_BOOST)
                trk_launched = 1'b1;
            else if (nxt == PH_ABORT)
            begin
                if ((prev == PH_BOOST && drogue_on_boost_abort) ||
                    (prev == PH_COAST && drogue_on_coast_abort))
                    r.fire_drogue = 1'b1;
            end
        end
        r.phase = trk_phase;
        return r;
    endfunction

    task automatic add_row(logic [OP_W-1:0] op, logic [TIME_W-1:0] stamp, bit fixed,
                           result_t want);
        row_t r;
        r.op = op;
        r.stamp = stamp;
        r.fixed = fixed;
        r.want = want;
        drill.push_back(r);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        cfg_write_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
    endtask

    task automatic load_settings(logic [TIME_W-1:0] arm_ms, logic [TIME_W-1:0] coast_ms,
                                 logic [TIME_W-1:0] abort_ms, logic pyro, logic boost_drg,
                                 logic coast_drg);
        write_reg(REG_ARMED_TIMEOUT, arm_ms);
        write_reg(REG_COAST_TIMEOUT, coast_ms);
        write_reg(REG_ABORT_TIMEOUT, abort_ms);
        write_reg(REG_PYRO_PRESENT, {31'b0, pyro});
        write_reg(REG_ABORT_DROGUE_BOOST, {31'b0, boost_drg});
        write_reg(REG_ABORT_DROGUE_COAST, {31'b0, coast_drg});
        cfg_write_en <= 1'b0;
        armed_to = arm_ms;
        coast_to = coast_ms;
        abort_to = abort_ms;
        pyro_on = pyro;
        drogue_on_boost_abort = boost_drg;
        drogue_on_coast_abort = coast_drg;
    endtask

    task automatic send_request(logic [OP_W-1:0] op, logic [TIME_W-1:0] stamp, bit fixed,
                                result_t want);
        result_t predicted;
        while ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {{(IN_W-OP_W-TIME_W){1'b0}}, stamp, op};
        do
            @(posedge clk);
        while (!s_tready);
        predicted = advance_phase(op, stamp);
        pending_results.push_back(fixed ? want : predicted);
    endtask

    task automatic wait_drained(int limit);
        int n;
        n = 0;
        while (pending_results.size() != 0 && n < limit)
        begin
            @(posedge clk);
            n++;
        end
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [TIME_W-1:0] pick_ms();
        case ($urandom_range(5))
            0: return '0;
            1: return '1;
            5: return $urandom;
            default: return $urandom_range(40, 1);
        endcase
    endfunction

    function automatic logic [OP_W-1:0] flight_command();
        int k;
        k = $urandom_range(4);
        case (trk_phase)
            PH_IDLE:   return OP_ARM;
            PH_ARMED:  return k < 3 ? OP_LAUNCH : (k == 3 ? OP_DISARM : OP_ABORT);
            PH_BOOST:  return k < 3 ? OP_BURNOUT : OP_ABORT;
            PH_COAST:  return k < 3 ? OP_APOGEE : OP_ABORT;
            PH_DROGUE: return k < 2 ? OP_MAIN : (k < 4 ? OP_LANDING : OP_ABORT);
            PH_MAIN:   return k < 4 ? OP_LANDING : OP_ABORT;
            default:   return OP_RESET;
        endcase
    endfunction

    task automatic cmp(string name, int unsigned exp, int unsigned act);
        if (exp != act)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, exp, act);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            if (pending_results.size() == 0)
            begin
                $error("result with nothing outstanding: %h", got);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                cmp("phase", 32'(want.phase), 32'(got.phase));
                cmp("phase_changed", 32'(want.phase_changed), 32'(got.phase_changed));
                cmp("fire_drogue", 32'(want.fire_drogue), 32'(got.fire_drogue));
                cmp("fire_main", 32'(want.fire_main), 32'(got.fire_main));
                cmp("beacon_start", 32'(want.beacon_start), 32'(got.beacon_start));
                cmp("reset_subsystems", 32'(want.reset_subsystems),
                    32'(got.reset_subsystems));
            end
        end
    end

    // receiver side, with one long hold-off to back the block up
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (hold_go && !hold_used)
        begin
            hold_used = 1'b1;
            hold_left = 300;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= stall_pct);
    end

    initial
    begin
        #3ms;
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        logic [OP_W-1:0]   op;
        logic [TIME_W-1:0] stamp;
        int                idle_mix[4];
        int                stall_mix[4];
        idle_mix = '{0, 51, 0, 18};
        stall_mix = '{0, 0, 51, 18};

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        load_settings('1, '0, '0, 1'b1, 1'b1, 1'b0);

        add_row(4'hF, '0, 1, mk(PH_IDLE, 0, 0, 0, 0, 0));
        add_row(OP_TICK, '1, 1, mk(PH_IDLE, 0, 0, 0, 0, 0));
        add_row(OP_DISARM, '0, 1, mk(PH_IDLE, 0, 0, 0, 0, 0));
        add_row(OP_ARM, '0, 1, mk(PH_ARMED, 1, 0, 0, 0, 0));
        // elapsed wraps to all ones and meets the largest armed timeout
        add_row(OP_TICK, 32'hFFFF_FFFE, 1, mk(PH_IDLE, 1, 0, 0, 0, 1));
        add_row(OP_ARM, '0, 1, mk(PH_ARMED, 1, 0, 0, 0, 0));
        add_row(OP_TICK, '0, 0, '0);
        add_row(OP_LAUNCH, '1, 1, mk(PH_BOOST, 1, 0, 0, 0, 0));
        add_row(OP_ABORT, '0, 1, mk(PH_ABORT, 1, 1, 0, 0, 0));
        add_row(OP_TICK, 32'd5, 1, mk(PH_ABORT, 0, 0, 0, 1, 0));
        add_row(OP_TICK, 32'd6, 0, '0);
        add_row(OP_RESET, '0, 1, mk(PH_IDLE, 1, 0, 0, 0, 1));
        add_row(OP_ARM, '0, 0, '0);
        add_row(OP_LAUNCH, '0, 0, '0);
        add_row(OP_BURNOUT, '0, 0, '0);
        add_row(OP_APOGEE, '0, 1, mk(PH_DROGUE, 1, 1, 0, 0, 0));
        add_row(OP_ABORT, '0, 0, '0);
        add_row(OP_MAIN, '0, 1, mk(PH_MAIN, 1, 0, 1, 0, 0));
        add_row(OP_ABORT, '0, 0, '0);
        add_row(OP_LANDING, '0, 0, '0);
        add_row(OP_RESET, '0, 0, '0);
        add_row(OP_ARM, '0, 0, '0);
        add_row(OP_ABORT, '0, 0, '0);
        // pad abort returns to idle
        add_row(OP_TICK, 32'd9, 1, mk(PH_IDLE, 1, 0, 0, 0, 1));
        add_row(OP_TICK, '0, 0, '0);

        foreach (drill[i])
            send_request(drill[i].op, drill[i].stamp, drill[i].fixed, drill[i].want);
        s_tvalid <= 1'b0;

        for (int ph = 0; ph < 4; ph++)
        begin
            wait_drained(5000);
            idle_pct = 0;
            stall_pct = 0;
            case (ph)
                0: load_settings('0, '0, '0, 1'b0, 1'b0, 1'b0);
                1: load_settings('1, '1, '1, 1'b1, 1'b1, 1'b1);
                default: load_settings(pick_ms(), pick_ms(), pick_ms(),
                                       1'($urandom_range(1)), 1'($urandom_range(1)),
                                       1'($urandom_range(1)));
            endcase
            idle_pct = idle_mix[ph];
            stall_pct = stall_mix[ph];
            clock_ms = (ph == 2) ? 32'hFFFF_FFC0 : $urandom;
            if (ph == 0)
                hold_go = 1'b1;
            repeat (125)
            begin
                if ($urandom_range(99) < 20)
                begin
                    op = OP_W'($urandom_range(15));
                    stamp = $urandom;
                end
                else if ($urandom_range(99) < 40)
                begin
                    clock_ms = clock_ms + $urandom_range(30);
                    op = OP_TICK;
                    stamp = clock_ms;
                end
                else
                begin
                    op = flight_command();
                    stamp = $urandom;
                end
                send_request(op, stamp, 1'b0, '0);
            end
            s_tvalid <= 1'b0;
        end

        wait_drained(5000);
        if (pending_results.size() != 0)
        begin
            $error("%0d results never arrived", pending_results.size());
            errors++;
        end
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
